/* hw/rtl/udaw_pkg.sv */
// Shared types and constants for the decimal ASCII writer.
`timescale 1ns / 1ps

package udaw_pkg;

  // Conversion geometry: ten BCD digits, 32 binary bits in four stages
  localparam int unsigned NUM_DIGITS     = 10;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned BCD_W          = 4 * NUM_DIGITS;
  localparam int unsigned NUM_STAGES     = 4;
  localparam int unsigned BITS_PER_STAGE = VALUE_W / NUM_STAGES;
  localparam int unsigned IDX_W          = 4;

  // Character codes
  localparam logic [5:0] CODE_ZERO  = 6'd48;
  localparam logic [5:0] CODE_COLON = 6'd58;

  // Payload of one conversion stage
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
    logic               with_colon;
    logic [31:0]        start_position;
  } conv_t;

endpackage

/* hw/rtl/uint32_decimal_ascii_writer.sv */
// A value passes the four conversion stages and then the serializer register
// before its first character shows. Throughput: one character per cycle while
// m_axis_tready is high; a value gives its digits and an optional colon (1 to 11
// characters), and the next value loads as the last character is taken.
// Reset (rst_ni low, asynchronous) empties every stage; no payload is cleared.
`timescale 1ns / 1ps

module uint32_decimal_ascii_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] value, [32] with_colon, [64:33] start_position, [71:65] zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] char_code, [37:6] char_position, [39:38] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned NS = udaw_pkg::NUM_STAGES;

  logic            valid [NS+1];
  logic            ready [NS+1];
  udaw_pkg::conv_t data  [NS+1];
  logic [5:0]      char_code;
  logic [31:0]     char_position;

  // Seed the conversion with an empty BCD word
  assign valid[0]            = s_axis_tvalid;
  assign s_axis_tready       = ready[0];
  assign data[0].bcd         = '0;
  assign data[0].bin         = s_axis_tdata[31:0];
  assign data[0].with_colon  = s_axis_tdata[32];
  assign data[0].start_position = s_axis_tdata[64:33];

  // Conversion pipeline
  for (genvar k = 0; k < NS; k++) begin : g_stage
    udaw_dabble_stage #(
      .STEPS(udaw_pkg::BITS_PER_STAGE)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid[k]),
      .ready_o(ready[k]),
      .data_i (data[k]),
      .valid_o(valid[k+1]),
      .ready_i(ready[k+1]),
      .data_o (data[k+1])
    );
  end

  // Character output
  udaw_serializer u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid[NS]),
    .ready_o        (ready[NS]),
    .data_i         (data[NS]),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .char_code_o    (char_code),
    .char_position_o(char_position),
    .last_char_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, char_position, char_code};

endmodule

/* hw/rtl/udaw_dabble_stage.sv */
// One registered stage of the shift-and-add-3 binary to BCD conversion.
`timescale 1ns / 1ps

module udaw_dabble_stage #(
  parameter int unsigned STEPS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  udaw_pkg::conv_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output udaw_pkg::conv_t data_o
);

  logic            valid_q, valid_d;
  udaw_pkg::conv_t data_q, data_d;

  // Run STEPS correct-then-shift iterations on the BCD and binary words
  function automatic udaw_pkg::conv_t dabble(udaw_pkg::conv_t c);
    udaw_pkg::conv_t               r;
    logic [udaw_pkg::BCD_W-1:0]    b;
    logic [udaw_pkg::VALUE_W-1:0]  n;
    r = c;
    b = c.bcd;
    n = c.bin;
    for (int s = 0; s < int'(STEPS); s++) begin
      for (int d = 0; d < int'(udaw_pkg::NUM_DIGITS); d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      {b, n} = {b[udaw_pkg::BCD_W-2:0], n, 1'b0};
    end
    r.bcd = b;
    r.bin = n;
    return r;
  endfunction

  // Load when empty or when the next stage takes the held transaction
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ready_o) begin
      valid_d = valid_i;
      if (valid_i) begin
        data_d = dabble(data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hw/rtl/udaw_serializer.sv */
// Character serializer: walks the BCD digits and an optional colon.
`timescale 1ns / 1ps

module udaw_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  udaw_pkg::conv_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [5:0]      char_code_o,
  output logic [31:0]     char_position_o,
  output logic            last_char_o
);

  logic                       busy_q, busy_d;
  logic [udaw_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                       colon_phase_q, colon_phase_d;
  logic                       colon_q, colon_d;
  logic [udaw_pkg::BCD_W-1:0] bcd_q, bcd_d;
  logic [31:0]                pos_q, pos_d;
  logic [udaw_pkg::IDX_W-1:0] lead;
  logic [3:0]                 digit;
  logic                       take;

  // Find the most significant nonzero digit, zero if all are zero
  always_comb begin
    lead = '0;
    for (int d = 0; d < int'(udaw_pkg::NUM_DIGITS); d++) begin
      if (data_i.bcd[d*4 +: 4] != 4'd0) begin
        lead = udaw_pkg::IDX_W'(d);
      end
    end
  end

  // Present the current character
  assign digit           = bcd_q[{idx_q, 2'b00} +: 4];
  assign valid_o         = busy_q;
  assign last_char_o     = colon_phase_q || ((idx_q == '0) && !colon_q);
  assign char_code_o     = colon_phase_q ? udaw_pkg::CODE_COLON
                                         : udaw_pkg::CODE_ZERO + {2'b00, digit};
  assign char_position_o = pos_q;
  assign take            = busy_q && ready_i;
  assign ready_o         = !busy_q || (take && last_char_o);

  // Advance through the digits, then the colon, then load the next value
  always_comb begin
    busy_d        = busy_q;
    idx_d         = idx_q;
    colon_phase_d = colon_phase_q;
    colon_d       = colon_q;
    bcd_d         = bcd_q;
    pos_d         = pos_q;
    if (take) begin
      if (last_char_o) begin
        busy_d = 1'b0;
      end else if (idx_q == '0) begin
        colon_phase_d = 1'b1;
        pos_d         = pos_q + 32'd1;
      end else begin
        idx_d = idx_q - 1'b1;
        pos_d = pos_q + 32'd1;
      end
    end
    if (valid_i && ready_o) begin
      busy_d        = 1'b1;
      idx_d         = lead;
      colon_phase_d = 1'b0;
      colon_d       = data_i.with_colon;
      bcd_d         = data_i.bcd;
      pos_d         = data_i.start_position;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      idx_q         <= '0;
      colon_phase_q <= 1'b0;
    end else begin
      busy_q        <= busy_d;
      idx_q         <= idx_d;
      colon_phase_q <= colon_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    colon_q <= colon_d;
    bcd_q   <= bcd_d;
    pos_q   <= pos_d;
  end

endmodule

/* hw/rtl/udaw_checker.sv */
// Port-level checker for the decimal ASCII writer, with its bind.
`timescale 1ns / 1ps

module udaw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic take;
  assign take = m_axis_tvalid && m_axis_tready;

  // A colon always closes the value
  a_colon_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[5:0] == udaw_pkg::CODE_COLON)) |-> m_axis_tlast)
    else $error("colon without last flag");

  // Codes stay within the digits and the colon
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[5:0] >= udaw_pkg::CODE_ZERO) &&
                       (m_axis_tdata[5:0] <= udaw_pkg::CODE_COLON)))
    else $error("character code out of range");

  // A character that is not last is followed at once by the next position
  a_next_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !m_axis_tlast) |=>
      (m_axis_tvalid && (m_axis_tdata[37:6] == $past(m_axis_tdata[37:6]) + 32'd1)))
    else $error("character run broken or position skipped");

  // A stalled character holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output changed");

endmodule

bind uint32_decimal_ascii_writer udaw_checker u_udaw_checker (.*);
